>>> rtl/register_dsl_tokenizer_defines.svh
// Assertion macros for the tokenizer checker.
`ifndef REGISTER_DSL_TOKENIZER_DEFINES_SVH
`define REGISTER_DSL_TOKENIZER_DEFINES_SVH
// Implication check, disabled while reset is asserted.
`define RDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication check, disabled while reset is asserted.
`define RDT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

>>> rtl/rdt_pkg.sv
// Shared types and constants for the register DSL tokenizer.
package rdt_pkg;
    localparam int POS_BITS = 20;
    localparam int LEN_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    typedef enum logic [2:0] {
        K_END = 3'd0, K_EQEQ = 3'd1, K_PUNCT = 3'd2, K_INT = 3'd3,
        K_KEYWORD = 3'd4, K_IDENT = 3'd5, K_ERROR = 3'd6, K_RSVD = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_EQ, M_DEC, M_HEX, M_IDENT, M_DISCARD
    } t_mode;

    localparam logic E_UNEXPECTED = 1'b0;
    localparam logic E_BAD_INT    = 1'b1;

    // one token
    typedef struct packed {
        t_kind               kind;
        logic [7:0]          punct_char;
        logic [63:0]         int_value;
        logic [2:0]          keyword_id;
        logic                error_code;
        logic [POS_BITS-1:0] start_line;
        logic [POS_BITS-1:0] start_col;
        logic [LEN_BITS-1:0] token_length;
    } t_tok;

    // up to three tokens caused by one byte
    typedef struct packed {
        logic [1:0] count;
        t_tok [2:0] tok;
    } t_group;

    // keyword lookup on first five bytes and length; returns id, hit flag in bit 3
    function automatic logic [3:0] kw_lookup(input logic [39:0] b, input logic [LEN_BITS-1:0] n);
        logic [3:0] r;
        r = 4'd0;
        if (n == LEN_BITS'(3) && b[23:0] == {"g","e","r"}) r = {1'b1, 3'd0};
        if (n == LEN_BITS'(5) && b == {"d","l","e","i","f"}) r = {1'b1, 3'd1};
        if (n == LEN_BITS'(5) && b == {"e","t","i","r","w"}) r = {1'b1, 3'd2};
        if (n == LEN_BITS'(4) && b[31:0] == {"l","l","o","p"}) r = {1'b1, 3'd3};
        if (n == LEN_BITS'(4) && b[31:0] == {"k","c","i","k"}) r = {1'b1, 3'd4};
        if (n == LEN_BITS'(2) && b[15:0] == {"o","r"}) r = {1'b1, 3'd5};
        if (n == LEN_BITS'(2) && b[15:0] == {"o","w"}) r = {1'b1, 3'd6};
        if (n == LEN_BITS'(2) && b[15:0] == {"w","r"}) r = {1'b1, 3'd7};
        return r;
    endfunction
endpackage

>>> rtl/rdt_scanner.sv
// Front end: per-byte scanner that produces the token group of each byte.
module rdt_scanner import rdt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output t_group     o_group
);
    t_mode               r_mode, n_mode;
    logic [63:0]         r_acc, n_acc;
    logic                r_ovf, n_ovf;
    logic [7:0]          r_dcnt, n_dcnt;
    logic [39:0]         r_wb, n_wb;
    logic [LEN_BITS-1:0] r_wlen, n_wlen;
    logic [POS_BITS-1:0] r_cl, n_cl, r_cc, n_cc, r_tl, n_tl, r_tc, n_tc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc <= '0; r_ovf <= 1'b0; r_dcnt <= '0; r_wb <= '0; r_wlen <= '0;
            r_cl <= POS_BITS'(1); r_cc <= POS_BITS'(1);
            r_tl <= POS_BITS'(1); r_tc <= POS_BITS'(1);
        end else if (i_valid) begin
            r_mode <= n_mode;
            r_acc <= n_acc; r_ovf <= n_ovf; r_dcnt <= n_dcnt; r_wb <= n_wb; r_wlen <= n_wlen;
            r_cl <= n_cl; r_cc <= n_cc; r_tl <= n_tl; r_tc <= n_tc;
        end
    end

    always_comb begin
        logic       fresh, is_dig, is_alp, is_hexl, is_pun, is_ws;
        logic [3:0] hv, dv, kw;
        logic [67:0] prod;
        t_tok       t;
        n_mode = r_mode; n_acc = r_acc; n_ovf = r_ovf; n_dcnt = r_dcnt;
        n_wb = r_wb; n_wlen = r_wlen; n_cl = r_cl; n_cc = r_cc; n_tl = r_tl; n_tc = r_tc;
        o_group = '0;
        fresh = 1'b0;
        is_dig = (i_ch >= "0") && (i_ch <= "9");
        is_alp = ((i_ch >= "a") && (i_ch <= "z")) || ((i_ch >= "A") && (i_ch <= "Z"));
        is_hexl = ((i_ch >= "a") && (i_ch <= "f")) || ((i_ch >= "A") && (i_ch <= "F"));
        is_pun = (i_ch == "@") || (i_ch == "{") || (i_ch == "}") || (i_ch == "[") ||
                 (i_ch == "]") || (i_ch == ".") || (i_ch == ",") || (i_ch == ":");
        is_ws = (i_ch == " ") || (i_ch == 8'h09) || (i_ch == 8'h0d) || (i_ch == 8'h0a);
        dv = i_ch[3:0];
        hv = is_dig ? i_ch[3:0] : 4'(i_ch[2:0] + 3'd1 + 4'd8);
        prod = 68'(r_acc) * 68'd10 + 68'(dv);
        t = '0;
        kw = kw_lookup(r_wb, r_wlen);

        case (r_mode)
            M_DISCARD: ;
            M_COMMENT: if (i_ch == 8'h0a) begin
                n_mode = M_IDLE; fresh = 1'b1;
            end
            M_SLASH: begin
                if (i_ch == "/") n_mode = M_COMMENT;
                else begin
                    t = '0; t.kind = K_ERROR; t.error_code = E_UNEXPECTED;
                    t.start_line = r_tl; t.start_col = r_tc;
                    o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
                    n_mode = M_DISCARD;
                end
            end
            M_EQ: begin
                t = '0; t.start_line = r_tl; t.start_col = r_tc;
                if (i_ch == "=") t.kind = K_EQEQ;
                else begin
                    t.kind = K_PUNCT; t.punct_char = "="; fresh = 1'b1;
                end
                o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
                n_mode = M_IDLE;
            end
            M_DEC: begin
                if (is_dig) begin
                    if (prod[67:64] != 4'd0) n_ovf = 1'b1;
                    n_acc = prod[63:0];
                    if (r_dcnt != 8'hff) n_dcnt = r_dcnt + 8'd1;
                end else if ((i_ch == "x" || i_ch == "X") && r_dcnt == 8'd1 && r_acc == '0) begin
                    n_dcnt = '0; n_mode = M_HEX;
                end else fresh = 1'b1;
            end
            M_HEX: begin
                if (is_dig || is_hexl) begin
                    if (r_acc[63:60] != 4'd0) n_ovf = 1'b1;
                    n_acc = {r_acc[59:0], hv};
                    if (r_dcnt != 8'hff) n_dcnt = r_dcnt + 8'd1;
                end else fresh = 1'b1;
            end
            M_IDENT: begin
                if (is_alp || is_dig || i_ch == "_") begin
                    if (r_wlen < LEN_BITS'(5)) n_wb = r_wb | (40'(i_ch) << {r_wlen[2:0], 3'b000});
                    if (r_wlen != LEN_MAX) n_wlen = r_wlen + LEN_BITS'(1);
                end else fresh = 1'b1;
            end
            default: begin
                n_mode = M_IDLE; fresh = 1'b1;
            end
        endcase

        // a literal or word ended by this byte (or the final byte) is flushed
        if (fresh && (r_mode == M_DEC || r_mode == M_HEX)) begin
            t = '0; t.start_line = r_tl; t.start_col = r_tc;
            if (r_ovf || r_dcnt == '0) begin
                t.kind = K_ERROR; t.error_code = E_BAD_INT; n_mode = M_DISCARD; fresh = 1'b0;
            end else begin
                t.kind = K_INT; t.int_value = r_acc; n_mode = M_IDLE;
            end
            o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
        end
        if (fresh && r_mode == M_IDENT) begin
            t = '0; t.start_line = r_tl; t.start_col = r_tc;
            if (kw[3]) begin t.kind = K_KEYWORD; t.keyword_id = kw[2:0]; end
            else begin t.kind = K_IDENT; t.token_length = r_wlen; end
            o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
            n_mode = M_IDLE;
        end

        if (fresh && !is_ws) begin
            n_tl = r_cl; n_tc = r_cc;
            if (i_ch == "#") n_mode = M_COMMENT;
            else if (i_ch == "/") n_mode = M_SLASH;
            else if (i_ch == "=") n_mode = M_EQ;
            else if (is_pun) begin
                t = '0; t.kind = K_PUNCT; t.punct_char = i_ch;
                t.start_line = r_cl; t.start_col = r_cc;
                o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
            end else if (is_dig) begin
                n_acc = 64'(dv); n_ovf = 1'b0; n_dcnt = 8'd1; n_mode = M_DEC;
            end else if (is_alp || i_ch == "_") begin
                n_wb = 40'(i_ch); n_wlen = LEN_BITS'(1); n_mode = M_IDENT;
            end else begin
                t = '0; t.kind = K_ERROR; t.error_code = E_UNEXPECTED;
                t.start_line = r_cl; t.start_col = r_cc;
                o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
                n_mode = M_DISCARD;
            end
        end

        if (i_ch == 8'h0a) begin
            if (r_cl != POS_MAX) n_cl = r_cl + POS_BITS'(1);
            n_cc = POS_BITS'(1);
        end else if (r_cc != POS_MAX) n_cc = r_cc + POS_BITS'(1);

        if (i_last) begin
            t = '0; t.start_line = n_tl; t.start_col = n_tc;
            case (n_mode)
                M_SLASH: begin
                    t.kind = K_ERROR; t.error_code = E_UNEXPECTED; n_mode = M_DISCARD;
                    o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
                end
                M_EQ: begin
                    t.kind = K_PUNCT; t.punct_char = "=";
                    o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
                end
                M_DEC, M_HEX: begin
                    if (n_ovf || n_dcnt == '0) begin
                        t.kind = K_ERROR; t.error_code = E_BAD_INT; n_mode = M_DISCARD;
                    end else begin
                        t.kind = K_INT; t.int_value = n_acc;
                    end
                    o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
                end
                M_IDENT: begin
                    kw = kw_lookup(n_wb, n_wlen);
                    if (kw[3]) begin t.kind = K_KEYWORD; t.keyword_id = kw[2:0]; end
                    else begin t.kind = K_IDENT; t.token_length = n_wlen; end
                    o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
                end
                default: ;
            endcase
            if (n_mode != M_DISCARD) begin
                t = '0; t.kind = K_END; t.start_line = n_cl; t.start_col = n_cc;
                o_group.tok[o_group.count] = t; o_group.count = o_group.count + 2'd1;
            end
            n_mode = M_IDLE; n_acc = '0; n_ovf = 1'b0; n_dcnt = '0; n_wb = '0; n_wlen = '0;
            n_cl = POS_BITS'(1); n_cc = POS_BITS'(1); n_tl = POS_BITS'(1); n_tc = POS_BITS'(1);
        end
    end
endmodule

>>> rtl/rdt_queue.sv
// Two-entry queue of token groups between scanner and emitter.
module rdt_queue import rdt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_data,
    output logic   o_full,
    output logic   o_empty,
    input  logic   i_pop,
    output t_group o_data
);
    t_group     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

>>> rtl/rdt_emitter.sv
// Back end: serializes a token group onto the output channel.
module rdt_emitter import rdt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_empty,
    input  t_group i_group,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_stall,
    output t_tok   o_tok,
    output logic   o_last
);
    logic [1:0] r_idx;
    logic       fire;

    assign o_valid = !i_empty;
    assign o_tok   = i_group.tok[r_idx];
    assign o_last  = (r_idx == i_group.count - 2'd1);
    assign fire    = o_valid && !i_stall;
    assign o_pop   = fire && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_idx <= 2'd0;
        else if (fire) r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
    end
endmodule

>>> rtl/register_dsl_tokenizer.sv
// Top level of the register DSL tokenizer.
// Usage:
//  Input channel: one source byte per request on i_ch, with i_last_byte set
//  on the final byte of a source; accepted when i_valid is high and o_stall low.
//  Output channel: one token per request on the o_* fields; o_last_result marks
//  the last token caused by an input byte. Accepted when o_valid and !i_stall.
//  The scanner front end classifies a byte combinationally and writes the 0..3
//  tokens it causes as one group into a two-deep queue; bytes that cause no
//  token do not enter the queue. The emitter back end sends one token a cycle
//  while the receiver does not stall. Throughput: one byte per cycle while the
//  queue has room. The first token of a byte is shown once its group is
//  registered in the queue and the groups ahead of it have been sent.
//  Reset (synchronous, active low) returns to line 1, column 1, empties the queue.
//  When the receiver stalls the queue fills and o_stall rises; the shown token
//  holds until taken.
module register_dsl_tokenizer import rdt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_ch,
    input  logic                i_last_byte,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_token_kind,
    output logic [7:0]          o_punct_char,
    output logic [63:0]         o_int_value,
    output logic [2:0]          o_keyword_id,
    output logic                o_error_code,
    output logic [POS_BITS-1:0] o_start_line,
    output logic [POS_BITS-1:0] o_start_col,
    output logic [LEN_BITS-1:0] o_token_length,
    output logic                o_last_result
);
    t_group grp, q_grp;
    logic   acc, full, empty, pop;
    t_tok   tok;

    assign o_stall = full;
    assign acc     = i_valid && !full;

    rdt_scanner u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc),
        .i_ch(i_ch), .i_last(i_last_byte), .o_group(grp)
    );

    rdt_queue u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(acc && grp.count != 2'd0),
        .i_data(grp), .o_full(full), .o_empty(empty), .i_pop(pop), .o_data(q_grp)
    );

    rdt_emitter u_emit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_group(q_grp),
        .o_pop(pop), .o_valid(o_valid), .i_stall(i_stall), .o_tok(tok),
        .o_last(o_last_result)
    );

    assign o_token_kind   = tok.kind;
    assign o_punct_char   = tok.punct_char;
    assign o_int_value    = tok.int_value;
    assign o_keyword_id   = tok.keyword_id;
    assign o_error_code   = tok.error_code;
    assign o_start_line   = tok.start_line;
    assign o_start_col    = tok.start_col;
    assign o_token_length = tok.token_length;
endmodule

>>> rtl/rdt_checker.sv
// Port-level checker for the tokenizer, bound to the top level.
`include "register_dsl_tokenizer_defines.svh"
module rdt_checker import rdt_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_token_kind,
    input logic [7:0] o_punct_char,
    input logic       o_last_result
);
    `RDT_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_token_kind))
    `RDT_ASSERT_IMP(a_kind, i_clk, i_rst_n, o_valid, o_token_kind != K_RSVD)
    `RDT_ASSERT_IMP(a_end_last, i_clk, i_rst_n, o_valid && o_token_kind == K_END, o_last_result)
    `RDT_ASSERT_IMP(a_punct, i_clk, i_rst_n, o_valid && o_token_kind != K_PUNCT,
                    o_punct_char == 8'd0)
endmodule

bind register_dsl_tokenizer rdt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_token_kind(o_token_kind), .o_punct_char(o_punct_char), .o_last_result(o_last_result)
);

>>> test/register_dsl_tokenizer_checker.sv
// Scoreboard for the register DSL tokenizer: tracks accepted bytes, predicts tokens, checks output.
module register_dsl_tokenizer_checker import rdt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [7:0]          i_ch,
    input  logic                i_last_byte,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [2:0]          i_token_kind,
    input  logic [7:0]          i_punct_char,
    input  logic [63:0]         i_int_value,
    input  logic [2:0]          i_keyword_id,
    input  logic                i_error_code,
    input  logic [POS_BITS-1:0] i_start_line,
    input  logic [POS_BITS-1:0] i_start_col,
    input  logic [LEN_BITS-1:0] i_token_length,
    input  logic                i_last_result,
    output int                  o_pending,
    output int                  o_fail_count
);
    typedef struct packed {
        t_tok tok;
        logic last;
    } t_exp_tok;

    t_exp_tok tok_fifo[$];
    t_exp_tok byte_toks[$];
    int       fails = 0;

    string kw_names[8] = '{"reg", "field", "write", "poll", "kick", "ro", "wo", "rw"};

    // scanner state
    t_mode               mode;
    logic [63:0]         acc;
    logic                ovf;
    logic [7:0]          ndig;
    logic [39:0]         wbytes;
    logic [LEN_BITS-1:0] wlen;
    logic [POS_BITS-1:0] cur_line, cur_col, tok_line, tok_col;

    assign o_pending    = tok_fifo.size();
    assign o_fail_count = fails;

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (is_digit(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic clear_scanner();
        mode = M_IDLE;
        acc = '0; ovf = 1'b0; ndig = '0;
        wbytes = '0; wlen = '0;
        cur_line = 1; cur_col = 1; tok_line = 1; tok_col = 1;
    endtask

    task automatic put(t_kind k, logic [7:0] pc, logic [63:0] v, logic [2:0] kw, logic e,
                       logic [POS_BITS-1:0] ln, logic [POS_BITS-1:0] cl,
                       logic [LEN_BITS-1:0] len);
        t_exp_tok x;
        x.tok.kind = k; x.tok.punct_char = pc; x.tok.int_value = v;
        x.tok.keyword_id = kw; x.tok.error_code = e;
        x.tok.start_line = ln; x.tok.start_col = cl; x.tok.token_length = len;
        x.last = 1'b0;
        byte_toks = {byte_toks, x};
    endtask

    task automatic raise_error(logic code);
        put(K_ERROR, 0, 0, 0, code, tok_line, tok_col, 0);
        mode = M_DISCARD;
    endtask

    task automatic close_number(output bit ok);
        if (ovf || ndig == 0) begin
            raise_error(E_BAD_INT);
            ok = 0;
        end else begin
            put(K_INT, 0, acc, 0, 0, tok_line, tok_col, 0);
            mode = M_IDLE;
            ok = 1;
        end
    endtask

    task automatic close_word();
        bit same;
        for (int k = 0; k < 8; k++) begin
            same = (wlen == kw_names[k].len());
            for (int i = 0; i < kw_names[k].len(); i++)
                if (same && wbytes[8*i +: 8] != kw_names[k][i]) same = 0;
            if (same) begin
                put(K_KEYWORD, 0, 0, k, 0, tok_line, tok_col, 0);
                mode = M_IDLE;
                return;
            end
        end
        put(K_IDENT, 0, 0, 0, 0, tok_line, tok_col, wlen);
        mode = M_IDLE;
    endtask

    task automatic add_word_byte(logic [7:0] c);
        if (wlen < 5) wbytes[8*wlen +: 8] = c;
        if (wlen != LEN_MAX) wlen++;
    endtask

    task automatic add_digit(logic [63:0] d, bit hex);
        if (hex) begin
            if (acc[63:60] != 0) ovf = 1'b1;
            acc = {acc[59:0], d[3:0]};
        end else begin
            if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) ovf = 1'b1;
            acc = acc * 10 + d;
        end
        if (ndig != 8'hFF) ndig++;
    endtask

    task automatic start_token(logic [7:0] c);
        string punct = "@{}[].,=:";
        bit    hit;
        if (c == " " || c == "\t" || c == 8'h0d || c == "\n") return;
        tok_line = cur_line;
        tok_col  = cur_col;
        hit = 0;
        for (int i = 0; i < punct.len(); i++) if (punct[i] == c) hit = 1;
        if (c == "#") mode = M_COMMENT;
        else if (c == "/") mode = M_SLASH;
        else if (c == "=") mode = M_EQ;
        else if (hit) put(K_PUNCT, c, 0, 0, 0, tok_line, tok_col, 0);
        else if (is_digit(c)) begin
            acc = '0; ovf = 1'b0; ndig = '0;
            add_digit(c - "0", 0);
            mode = M_DEC;
        end else if (is_alpha(c) || c == "_") begin
            wbytes = '0; wlen = '0;
            add_word_byte(c);
            mode = M_IDENT;
        end else raise_error(E_UNEXPECTED);
    endtask

    // one accepted byte: append its tokens to the fifo
    task automatic scan_byte(logic [7:0] c, logic last);
        bit fresh, ok;
        int h;
        fresh = 0;
        case (mode)
            M_DISCARD: ;
            M_COMMENT: if (c == "\n") begin
                mode = M_IDLE; fresh = 1;
            end
            M_SLASH: if (c == "/") mode = M_COMMENT; else raise_error(E_UNEXPECTED);
            M_EQ: begin
                if (c == "=") put(K_EQEQ, 0, 0, 0, 0, tok_line, tok_col, 0);
                else begin
                    put(K_PUNCT, "=", 0, 0, 0, tok_line, tok_col, 0);
                    fresh = 1;
                end
                mode = M_IDLE;
            end
            M_DEC: begin
                if (is_digit(c)) add_digit(c - "0", 0);
                else if ((c == "x" || c == "X") && ndig == 1 && acc == 0) begin
                    ndig = 0;
                    mode = M_HEX;
                end else begin
                    close_number(ok); fresh = ok;
                end
            end
            M_HEX: begin
                h = hex_digit(c);
                if (h >= 0) add_digit(h, 1);
                else begin
                    close_number(ok); fresh = ok;
                end
            end
            M_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") add_word_byte(c);
                else begin
                    close_word(); fresh = 1;
                end
            end
            default: begin
                mode = M_IDLE; fresh = 1;
            end
        endcase
        if (fresh) start_token(c);

        if (c == "\n") begin
            if (cur_line != POS_MAX) cur_line++;
            cur_col = 1;
        end else if (cur_col != POS_MAX) cur_col++;

        if (last) begin
            case (mode)
                M_SLASH: raise_error(E_UNEXPECTED);
                M_EQ: begin
                    put(K_PUNCT, "=", 0, 0, 0, tok_line, tok_col, 0);
                    mode = M_IDLE;
                end
                M_DEC, M_HEX: close_number(ok);
                M_IDENT: close_word();
                default: ;
            endcase
            if (mode != M_DISCARD) put(K_END, 0, 0, 0, 0, cur_line, cur_col, 0);
            clear_scanner();
        end

        if (byte_toks.size() > 0) byte_toks[byte_toks.size()-1].last = 1'b1;
        tok_fifo = {tok_fifo, byte_toks};
        byte_toks.delete();
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_exp_tok e;
        if (!i_rst_n) begin
            clear_scanner();
            tok_fifo.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (tok_fifo.size() == 0) begin
                    $error("token with no request pending: kind %0d", i_token_kind);
                    fails++;
                end else begin
                    e = tok_fifo.pop_front();
                    check_field("token_kind", e.tok.kind, i_token_kind);
                    check_field("punct_char", e.tok.punct_char, i_punct_char);
                    check_field("int_value", e.tok.int_value, i_int_value);
                    check_field("keyword_id", e.tok.keyword_id, i_keyword_id);
                    check_field("error_code", e.tok.error_code, i_error_code);
                    check_field("start_line", e.tok.start_line, i_start_line);
                    check_field("start_col", e.tok.start_col, i_start_col);
                    check_field("token_length", e.tok.token_length, i_token_length);
                    check_field("last_result", e.last, i_last_result);
                end
            end
            if (i_in_valid && !i_in_stall) scan_byte(i_ch, i_last_byte);
        end
    end
endmodule

>>> test/register_dsl_tokenizer_tb.sv
// Testbench top for the register DSL tokenizer: source stimulus, output stalls and verdict.
module register_dsl_tokenizer_tb;
    import rdt_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [7:0]          i_ch = '0;
    logic                i_last_byte = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [2:0]          o_token_kind;
    logic [7:0]          o_punct_char;
    logic [63:0]         o_int_value;
    logic [2:0]          o_keyword_id;
    logic                o_error_code;
    logic [POS_BITS-1:0] o_start_line;
    logic [POS_BITS-1:0] o_start_col;
    logic [LEN_BITS-1:0] o_token_length;
    logic                o_last_result;

    int tokens_pending;
    int fail_count;

    // Shared knobs between the byte sender and the token receiver.
    bit calm = 0;        // no gaps, no stalls for the current source
    bit hold_req = 0;    // receiver freezes for a long stretch
    int bytes_sent = 0;

    logic [7:0] src_bytes[$];   // current source being assembled

    string keywords[8] = '{"reg", "field", "write", "poll", "kick", "ro", "wo", "rw"};

    always #5 i_clk = ~i_clk;

    register_dsl_tokenizer dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_ch, .i_last_byte,
        .o_valid, .i_stall, .o_token_kind, .o_punct_char, .o_int_value,
        .o_keyword_id, .o_error_code, .o_start_line, .o_start_col,
        .o_token_length, .o_last_result
    );

    register_dsl_tokenizer_checker scoreboard (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_ch, .i_last_byte,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_token_kind(o_token_kind), .i_punct_char(o_punct_char),
        .i_int_value(o_int_value), .i_keyword_id(o_keyword_id),
        .i_error_code(o_error_code), .i_start_line(o_start_line),
        .i_start_col(o_start_col), .i_token_length(o_token_length),
        .i_last_result(o_last_result),
        .o_pending(tokens_pending), .o_fail_count(fail_count)
    );

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_char(string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic add_byte(logic [7:0] c);
        src_bytes = {src_bytes, c};
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // Offer one byte and hold it until taken; then maybe drop valid for a gap.
    task automatic send_byte(logic [7:0] c, logic last);
        int gap;
        i_ch        <= c;
        i_last_byte <= last;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        gap = calm ? 0 : pick_idle();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send the assembled source; the final byte carries the last flag.
    task automatic flush_source();
        logic [7:0] c;
        while (src_bytes.size() > 0) begin
            c = src_bytes.pop_front();
            send_byte(c, src_bytes.size() == 0);
        end
    endtask

    // Append one random lexical piece to the source.
    task automatic add_piece();
        string alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        string word  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        string hexd  = "0123456789abcdefABCDEF";
        string punct = "@{}[].,:";
        int n;
        case ($urandom_range(0, 15))
            0, 1: push_text(keywords[$urandom_range(0, 7)]);
            2: begin
                // keyword-like words that must not match
                push_text(keywords[$urandom_range(0, 7)]);
                add_byte(pick_char(word));
            end
            3, 4: begin
                add_byte(pick_char(alpha));
                n = $urandom_range(0, 7);
                repeat (n) add_byte(pick_char(word));
            end
            5, 6: begin
                n = $urandom_range(1, 20);
                add_byte(($urandom_range(0, 5) == 0) ? "0" : pick_char("123456789"));
                repeat (n - 1) add_byte(pick_char("0123456789"));
            end
            7: begin
                // right at the 64-bit boundary: last digit 5 fits, 6..9 overflow
                push_text("1844674407370955161");
                add_byte(pick_char("56789"));
            end
            8, 9: begin
                push_text($urandom_range(0, 1) ? "0x" : "0X");
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 17);
                repeat (n) add_byte(pick_char(hexd));
            end
            10, 11: add_byte(pick_char(punct));
            12: push_text($urandom_range(0, 1) ? "==" : "=");
            13: begin
                // comment body may hold any byte from 11 to 255, so never a newline
                push_text($urandom_range(0, 1) ? "#" : "//");
                n = $urandom_range(0, 6);
                repeat (n) add_byte(8'($urandom_range(11, 255)));
                add_byte("\n");
            end
            14: add_byte(pick_char(" \t\015\n"));
            default: begin
                // noise: stray slash or any byte at all
                if ($urandom_range(0, 1)) add_byte("/");
                else add_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Receiver: random stalls, calm stretches, and one long hold on request.
    initial begin
        int n;
        i_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (150) @(posedge i_clk);
                hold_req = 0;
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (calm) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = pick_idle();
                i_stall <= (n > 0);
                repeat ((n > 0) ? n : $urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: far above the slowest legal run.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int src_count;
        int npieces;
        int drain;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every keyword, identifier, == and all punctuation.
        calm = 1;
        push_text("reg field write poll kick ro wo rw _x9 == = @{}[].,:");
        flush_source();
        calm = 0;
        // Decimal and hex extremes, comments, pending equals at the end.
        push_text("0 0x1F 0XaB 18446744073709551615\n#c\015\n// d\t\n=");
        flush_source();
        push_text("18446744073709551616 a");   // decimal overflow, then discarded
        flush_source();
        push_text("0x ");                       // hex prefix with no digit
        flush_source();
        push_text("/a b");                      // lone slash mid-source
        flush_source();
        push_text("a/");                        // slash as the final byte
        flush_source();
        push_text("0xFFFFFFFFFFFFFFFFF");       // hex overflow at end of source
        flush_source();
        add_byte(8'h00);                        // NUL
        flush_source();
        add_byte(8'hFF);                        // byte above 127
        push_text("zz");
        flush_source();
        push_text("x");                         // one-byte source
        flush_source();

        // Random sources until enough bytes have gone through.
        src_count = 0;
        while (bytes_sent < 480) begin
            calm = ($urandom_range(0, 4) == 0);
            // long receiver hold while bytes keep coming
            if (src_count == 4) hold_req = 1;
            // sender waits for the pipeline to empty
            if (src_count == 20) begin
                while (tokens_pending != 0) @(posedge i_clk);
            end
            npieces = $urandom_range(1, 12);
            for (int p = 0; p < npieces; p++) begin
                add_piece();
                if ($urandom_range(0, 4) != 0) add_byte(pick_char(" \t\015\n"));
            end
            flush_source();
            src_count++;
        end
        i_valid <= 1'b0;
        calm = 1;

        while (tokens_pending != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 20) begin
            @(posedge i_clk);
            drain++;
        end
        if (fail_count == 0 && tokens_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> register_dsl_tokenizer.f
+incdir+rtl
rtl/rdt_pkg.sv
rtl/rdt_scanner.sv
rtl/rdt_queue.sv
rtl/rdt_emitter.sv
rtl/register_dsl_tokenizer.sv
rtl/rdt_checker.sv
test/register_dsl_tokenizer_checker.sv
test/register_dsl_tokenizer_tb.sv
